// ===== rtl/brpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Block RMS peak meter package
// Payload types, controller command and status types, and fixed widths.
// ----------------------------------------------------------------------------
package brpm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RMS_W    = 24;
	// The mean of squares never exceeds 2^30, so it fits in 31 bits.
	localparam int MEAN_W   = 31;
	// The mean is scaled by 2^16 before the root to give 8 fraction bits.
	localparam int SQ_SHIFT = 16;
	localparam int RAD_W    = 2 * RMS_W;
	localparam int SQ_STEPS = RMS_W;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
		logic                       restart_peak;
	} brpm_in_t;

	typedef struct packed {
		logic [RMS_W-1:0] block_rms;
		logic [RMS_W-1:0] peak_rms;
	} brpm_out_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic sq_load;
		logic sq_step;
		logic emit;
	} brpm_cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} brpm_sts_t;

endpackage
`default_nettype wire

// ===== rtl/brpm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Block RMS peak meter controller
// Sequences accumulation, the bit-serial divide, the square root and the
// result load.
// ----------------------------------------------------------------------------
module brpm_ctrl #(
	parameter int SUM_W = 43
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire brpm_pkg::brpm_sts_t   sts,
	output brpm_pkg::brpm_cmd_t        cmd
);
	import brpm_pkg::*;

	localparam int ITR_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_DIV,
		ST_SQLD,
		ST_SQRT,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [ITR_W-1:0] itr_q;
	logic             accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.div_step = (state_q == ST_DIV);
		cmd.sq_load  = (state_q == ST_SQLD);
		cmd.sq_step  = (state_q == ST_SQRT);
		cmd.emit     = (state_q == ST_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			itr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && sts.last) begin
						state_q <= ST_DRAIN;
					end
				end
				// The square of the final request is added to the sum here.
				ST_DRAIN: begin
					itr_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (itr_q == ITR_W'(SUM_W - 1)) begin
						state_q <= ST_SQLD;
					end
					itr_q <= itr_q + 1'b1;
				end
				ST_SQLD: begin
					itr_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (itr_q == ITR_W'(SQ_STEPS - 1)) begin
						state_q <= ST_EMIT;
					end
					itr_q <= itr_q + 1'b1;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/brpm_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Block RMS peak meter datapath
// Square accumulator, restoring divider, digit-by-digit square root, running
// peak and the result register.
// ----------------------------------------------------------------------------
module brpm_dp #(
	parameter int MAX_BLOCK = 4096,
	parameter int CNT_W     = 13,
	parameter int SUM_W     = 43
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire brpm_pkg::brpm_in_t   item,
	input  wire brpm_pkg::brpm_cmd_t  cmd,
	output brpm_pkg::brpm_sts_t       sts,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output brpm_pkg::brpm_out_t       result
);
	import brpm_pkg::*;

	logic [SAMPLE_W-1:0]   mag;
	logic [2*SAMPLE_W-1:0] sq_full;
	logic [MEAN_W-1:0]     square_s1;
	logic                  sq_vld_s1;

	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W:0]        div_try;
	logic                  div_ge;

	logic [RAD_W-1:0]      rad_q;
	logic [RMS_W-1:0]      root_q;
	logic [RMS_W+1:0]      srem_q;
	logic [RMS_W+3:0]      sq_cur;
	logic [RMS_W+3:0]      sq_trial;
	logic                  sq_ge;

	logic [RMS_W-1:0]      peak_q;
	logic [RMS_W-1:0]      peak_new;
	logic                  res_vld_q;
	brpm_out_t             res_q;

	assign mag     = item.sample[SAMPLE_W-1] ? SAMPLE_W'(-item.sample)
	                                         : SAMPLE_W'(item.sample);
	assign sq_full = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);

	// The block also ends when this request fills it to the maximum length.
	assign sts.last     = item.block_end || (count_q == CNT_W'(MAX_BLOCK - 1));
	assign sts.out_free = !res_vld_q || result_ready;

	assign div_try = {rem_q, sum_q[SUM_W-1]};
	assign div_ge  = (div_try >= {1'b0, count_q});

	assign sq_cur   = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_cur >= sq_trial);

	assign peak_new = (peak_q < root_q) ? root_q : peak_q;

	// Square pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1 <= 1'b0;
		end else begin
			sq_vld_s1 <= cmd.accept;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			square_s1 <= sq_full[MEAN_W-1:0];
		end
	end

	// Sum register doubles as the dividend shifter; it ends up holding the quotient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			peak_q  <= '0;
		end else begin
			if (cmd.emit) begin
				sum_q <= '0;
			end else if (cmd.div_step) begin
				sum_q <= {sum_q[SUM_W-2:0], div_ge};
			end else if (sq_vld_s1) begin
				sum_q <= sum_q + SUM_W'(square_s1);
			end

			if (cmd.emit) begin
				count_q <= '0;
			end else if (cmd.accept) begin
				count_q <= count_q + 1'b1;
			end

			if (cmd.accept && item.restart_peak) begin
				peak_q <= '0;
			end else if (cmd.emit) begin
				peak_q <= peak_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? CNT_W'(div_try - {1'b0, count_q}) : div_try[CNT_W-1:0];
		end
	end

	// Two radicand bits per step, one root bit per step.
	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			rad_q  <= {{(RAD_W - MEAN_W - SQ_SHIFT){1'b0}}, sum_q[MEAN_W-1:0],
			           {SQ_SHIFT{1'b0}}};
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sq_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (sq_ge) begin
				srem_q <= (RMS_W+2)'(sq_cur - sq_trial);
				root_q <= {root_q[RMS_W-2:0], 1'b1};
			end else begin
				srem_q <= sq_cur[RMS_W+1:0];
				root_q <= {root_q[RMS_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				res_vld_q <= 1'b1;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.block_rms <= root_q;
			res_q.peak_rms  <= peak_new;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	a_peak_ge_rms: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.peak_rms >= result.block_rms))
		else $error("peak below block rms");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("result not presented after load");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) <= MAX_BLOCK))
		else $error("sample count beyond maximum block");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.sq_step) |-> !cmd.accept)
		else $error("request taken during divide or root");
`endif

endmodule
`default_nettype wire

// ===== rtl/block_rms_peak_meter_unit.sv =====
`default_nettype none
// Throughput: one sample per cycle while a block accumulates.
// After a block-ending sample the unit is busy and takes no new sample while the
// one-bit-per-cycle divider and the 24-step square root run.
// The result becomes valid once the drain, divide, root load, square root and emit
// states have run; an earlier result still waiting holds the unit and the load in emit.
// Reset clears the sum, count, peak and all valid flags at once.
// ----------------------------------------------------------------------------
// Block RMS peak meter
// Accumulates squared samples per block, emits block RMS and running peak.
// ----------------------------------------------------------------------------
module block_rms_peak_meter_unit #(
	parameter int MAX_BLOCK = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire brpm_pkg::brpm_in_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output brpm_pkg::brpm_out_t      result
);
	import brpm_pkg::*;

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W = 30 + CNT_W;

	brpm_cmd_t cmd;
	brpm_sts_t sts;

	brpm_ctrl #(
		.SUM_W(SUM_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	brpm_dp #(
		.MAX_BLOCK (MAX_BLOCK),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block RMS peak meter testbench
// Drives sample requests with random gaps against a randomly stalled result
// side, predicts each block RMS and running peak, and checks every result.
// ----------------------------------------------------------------------------
module testbench;

	import brpm_pkg::*;

	localparam int BLOCK_LIMIT   = 4096;
	localparam int SETTLE_CYCLES = 120;
	localparam int RANDOM_ITEMS  = 900;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	brpm_in_t  item;
	logic      result_valid;
	logic      result_ready;
	brpm_out_t result;

	// Predicted block state.
	logic [63:0] energy_acc;
	int          block_len;
	logic [23:0] peak_hold;

	brpm_out_t levels_due[$];
	int        errors;
	bit        tx_free;
	bit        rx_free;

	block_rms_peak_meter_unit #(
		.MAX_BLOCK(BLOCK_LIMIT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("block_rms_peak_meter_unit: mismatch");
		$finish;
	end

	// Floor of the square root, one result bit per pass from the top down.
	function automatic logic [23:0] root_floor(input logic [63:0] radicand);
		logic [63:0] trial;
		logic [31:0] acc;
		acc = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = {32'd0, acc | (32'd1 << b)};
			if (trial * trial <= radicand)
				acc = acc | (32'd1 << b);
		end
		return acc[23:0];
	endfunction

	task automatic track_level(input brpm_in_t it);
		int          s;
		logic [63:0] mag;
		logic [63:0] mean;
		brpm_out_t   lvl;
		s = it.sample;
		if (it.restart_peak)
			peak_hold = '0;
		mag = (s < 0) ? 64'(-s) : 64'(s);
		energy_acc = energy_acc + mag * mag;
		block_len++;
		if (it.block_end || block_len >= BLOCK_LIMIT) begin
			mean = energy_acc / 64'(block_len);
			lvl.block_rms = root_floor(mean << SQ_SHIFT);
			if (peak_hold < lvl.block_rms)
				peak_hold = lvl.block_rms;
			lvl.peak_rms = peak_hold;
			levels_due.push_back(lvl);
			energy_acc = '0;
			block_len = 0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_sample(input brpm_in_t it);
		int gap;
		gap = tx_free ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		track_level(it);
	endtask

	task automatic send_block_sample(input int value, input bit last, input bit restart);
		brpm_in_t it;
		it.sample = 16'(value);
		it.block_end = last;
		it.restart_peak = restart;
		send_sample(it);
	endtask

	// Hold off the sender until the block has delivered everything and gone quiet.
	task automatic drain();
		@(negedge clk);
		item_valid = 1'b0;
		wait (levels_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls, a few of them long.
	initial begin
		int hold;
		hold = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (rx_free) begin
				result_ready = 1'b1;
			end else begin
				result_ready = ($urandom_range(0, 3) != 0);
				if (result_ready)
					hold = $urandom_range(0, 4);
				else if ($urandom_range(0, 9) == 0)
					hold = $urandom_range(20, 40);
				else
					hold = $urandom_range(0, 2);
			end
		end
	end

	initial begin
		brpm_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				if (levels_due.size() == 0) begin
					$display("%0t: unexpected result block_rms %0d peak_rms %0d", $time,
						result.block_rms, result.peak_rms);
					errors++;
				end else begin
					want = levels_due.pop_front();
					if (result.block_rms !== want.block_rms) begin
						$display("%0t: block_rms expected %0d, got %0d", $time,
							want.block_rms, result.block_rms);
						errors++;
					end
					if (result.peak_rms !== want.peak_rms) begin
						$display("%0t: peak_rms expected %0d, got %0d", $time,
							want.peak_rms, result.peak_rms);
						errors++;
					end
				end
			end
		end
	end

	task automatic test_single_sample_blocks();
		send_block_sample(0, 1'b1, 1'b0);
		send_block_sample(32767, 1'b1, 1'b0);
		send_block_sample(-32768, 1'b1, 1'b0);
		send_block_sample(1, 1'b1, 1'b0);
		send_block_sample(-1, 1'b1, 1'b0);
		send_block_sample(16'h5555, 1'b1, 1'b0);
		drain();
	endtask

	task automatic test_mean_truncation();
		send_block_sample(3, 1'b0, 1'b0);
		send_block_sample(-5, 1'b1, 1'b0);
		send_block_sample(1, 1'b0, 1'b0);
		send_block_sample(1, 1'b0, 1'b0);
		send_block_sample(0, 1'b1, 1'b0);
		send_block_sample(-32768, 1'b0, 1'b0);
		send_block_sample(32767, 1'b1, 1'b0);
		drain();
	endtask

	task automatic test_peak_restart();
		// A restart on a mid-block sample clears the peak without a result.
		send_block_sample(100, 1'b0, 1'b1);
		send_block_sample(50, 1'b1, 1'b0);
		send_block_sample(10, 1'b1, 1'b0);
		// A restart on the closing sample leaves the peak at this block's level.
		send_block_sample(-7, 1'b0, 1'b0);
		send_block_sample(7, 1'b1, 1'b1);
		drain();
	endtask

	task automatic test_block_overflow();
		// Full-scale block that ends only through the length limit.
		tx_free = 1'b1;
		for (int k = 0; k < BLOCK_LIMIT; k++)
			send_block_sample(-32768, 1'b0, 1'b0);
		send_block_sample(12, 1'b0, 1'b0);
		send_block_sample(-9, 1'b1, 1'b0);
		tx_free = 1'b0;
		for (int k = 0; k < BLOCK_LIMIT; k++)
			send_block_sample(int'($urandom_range(0, 65535)), 1'b0, k == 0);
		drain();
	endtask

	function automatic int random_sample(input int shift);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 4))
				0: return 32767;
				1: return -32768;
				2: return 1;
				3: return -1;
				default: return 0;
			endcase
		end
		return int'($signed(16'($urandom))) >>> shift;
	endfunction

	task automatic test_random_blocks();
		int       sent;
		int       len;
		int       shift;
		int       r;
		brpm_in_t it;
		sent = 0;
		tx_free = 1'b1;
		rx_free = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= 150) begin
				tx_free = ($urandom_range(0, 9) == 0);
				rx_free = ($urandom_range(0, 9) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 6);
			else if (r < 95)
				len = $urandom_range(7, 40);
			else
				len = $urandom_range(41, 150);
			shift = $urandom_range(0, 15);
			for (int k = 0; k < len; k++) begin
				it.sample = 16'(random_sample(shift));
				it.block_end = (k == len - 1);
				it.restart_peak = ($urandom_range(0, 19) == 0);
				send_sample(it);
				sent++;
			end
			if ($urandom_range(0, 29) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		errors = 0;
		tx_free = 1'b0;
		rx_free = 1'b0;
		energy_acc = '0;
		block_len = 0;
		peak_hold = '0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_sample_blocks();
		test_mean_truncation();
		test_peak_restart();
		test_block_overflow();
		test_random_blocks();

		if (errors == 0)
			$display("block_rms_peak_meter_unit: match");
		else
			$display("block_rms_peak_meter_unit: mismatch");
		$finish;
	end

endmodule

// ===== block_rms_peak_meter_unit.f =====
rtl/brpm_pkg.sv
rtl/brpm_ctrl.sv
rtl/brpm_dp.sv
rtl/block_rms_peak_meter_unit.sv
tb/testbench.sv
